[hw/rtl/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [15:0] REPL_UNIT = 16'hFFFD;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  // One decoded byte: one or two results. The last result is the end item
  // when term is set, otherwise a unit.
  typedef struct packed {
    logic        dual;
    logic        term;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } cmd_t;

endpackage

[hw/rtl/u8u16_front.sv]
// ----------------------------------------------------------------------------
// u8u16_front
// Byte classifier and code point assembler; issues result commands.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               q_full_i,
  output logic               push_o,
  output u8u16_pkg::cmd_t    cmd_o
);
  import u8u16_pkg::*;

  localparam logic [20:0] BMP_MAX  = 21'h00FFFF;
  localparam logic [20:0] CP_LIMIT = 21'h10FFFD;
  localparam logic [20:0] SUPP_OFS = 21'h010000;

  logic [20:0] partial_q, partial_d;
  logic [1:0]  remain_q, remain_d;

  logic        accept;
  logic        is_cont;
  logic [1:0]  lead_rem;
  logic [20:0] lead_val;
  logic [20:0] next_val;
  logic [20:0] supp;
  logic        lead_unit;
  logic [15:0] lead_code;
  logic        has_cmd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_cont    = (in_byte_i[7:6] == 2'b10);
  assign next_val   = {partial_q[14:0], in_byte_i[5:0]};
  assign supp       = next_val - SUPP_OFS;

  always_comb begin
    if (in_byte_i[7:4] inside {4'hC, 4'hD}) begin
      lead_rem = 2'd1;
      lead_val = {16'b0, in_byte_i[4:0]};
    end else if (in_byte_i[7:4] == 4'hE) begin
      lead_rem = 2'd2;
      lead_val = {17'b0, in_byte_i[3:0]};
    end else if (in_byte_i[7:4] == 4'hF) begin
      lead_rem = 2'd3;
      lead_val = {18'b0, in_byte_i[2:0]};
    end else begin
      lead_rem = 2'd0;
      lead_val = '0;
    end
  end

  always_comb begin
    lead_unit = 1'b0;
    lead_code = {8'b0, in_byte_i};
    if (is_cont) begin
      lead_unit = 1'b1;
      lead_code = REPL_UNIT;
    end else if (lead_rem == 2'd0) begin
      lead_unit = 1'b1;
    end
  end

  always_comb begin
    partial_d   = partial_q;
    remain_d    = remain_q;
    has_cmd     = 1'b0;
    cmd_o.dual  = 1'b0;
    cmd_o.term  = 1'b0;
    cmd_o.unit0 = REPL_UNIT;
    cmd_o.unit1 = REPL_UNIT;
    if (in_byte_i == 8'h00) begin
      has_cmd    = 1'b1;
      cmd_o.term = 1'b1;
      cmd_o.dual = (remain_q != 2'd0);
      partial_d  = '0;
      remain_d   = 2'd0;
    end else if (remain_q != 2'd0 && is_cont) begin
      remain_d = remain_q - 2'd1;
      if (remain_q == 2'd1) begin
        partial_d = '0;
        has_cmd   = 1'b1;
        if (next_val <= BMP_MAX) begin
          cmd_o.unit0 = next_val[15:0];
        end else if (next_val <= CP_LIMIT) begin
          cmd_o.dual  = 1'b1;
          cmd_o.unit0 = 16'hD800 | {6'b0, supp[19:10]};
          cmd_o.unit1 = 16'hDC00 | {6'b0, supp[9:0]};
        end
      end else begin
        partial_d = next_val;
      end
    end else begin
      partial_d = lead_unit ? '0 : lead_val;
      remain_d  = lead_unit ? 2'd0 : lead_rem;
      if (remain_q != 2'd0) begin
        has_cmd     = 1'b1;
        cmd_o.dual  = lead_unit;
        cmd_o.unit1 = lead_code;
      end else if (lead_unit) begin
        has_cmd     = 1'b1;
        cmd_o.unit0 = lead_code;
      end
    end
  end

  assign push_o = accept && has_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      remain_q  <= 2'd0;
    end else if (accept) begin
      partial_q <= partial_d;
      remain_q  <= remain_d;
    end
  end

endmodule

[hw/rtl/u8u16_queue.sv]
// ----------------------------------------------------------------------------
// u8u16_queue
// Small command queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module u8u16_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  u8u16_pkg::cmd_t    wr_data_i,
  output logic               full_o,
  input  logic               rd_en_i,
  output u8u16_pkg::cmd_t    rd_data_o,
  output logic               empty_o
);
  import u8u16_pkg::*;

  cmd_t            mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]   count_q, count_d;

  assign full_o    = (count_q == (Q_AW+1)'(Q_DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (rd_en_i && !wr_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> !full_o) else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !empty_o) else $error("queue read while empty");

endmodule

[hw/rtl/u8u16_back.sv]
// ----------------------------------------------------------------------------
// u8u16_back
// Output sequencer: expands commands into results and keeps the unit count.
// ----------------------------------------------------------------------------
module u8u16_back #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  u8u16_pkg::cmd_t    cmd_i,
  input  logic               q_empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        code_unit_o,
  output logic               unit_valid_o,
  output logic               string_done_o,
  output logic [15:0]        total_units_o
);
  import u8u16_pkg::*;

  logic                  sub_q, sub_d;
  logic                  out_valid_q;
  logic [15:0]           code_q, total_q;
  logic                  uvalid_q, done_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [15:0]           cnt_sat;

  logic        load;
  logic        sel_end;
  logic [15:0] sel_code;

  generate
    if (COUNT_BITS > 16) begin : g_wide
      assign cnt_sat = (cnt_q > COUNT_BITS'(17'h0FFFF)) ? 16'hFFFF : cnt_q[15:0];
    end else begin : g_narrow
      assign cnt_sat = 16'(cnt_q);
    end
  endgenerate

  assign load = !q_empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    sub_d    = sub_q;
    pop_o    = 1'b0;
    sel_end  = 1'b0;
    sel_code = cmd_i.unit0;
    if (sub_q) begin
      sel_end  = cmd_i.term;
      sel_code = cmd_i.unit1;
    end else if (!cmd_i.dual) begin
      sel_end = cmd_i.term;
    end
    if (load) begin
      if (!sub_q && cmd_i.dual) begin
        sub_d = 1'b1;
      end else begin
        sub_d = 1'b0;
        pop_o = 1'b1;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      if (sel_end) begin
        cnt_d = '0;
      end else if (cnt_q != '1) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      sub_q <= sub_d;
      cnt_q <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q   <= sel_end ? 16'h0000 : sel_code;
      total_q  <= sel_end ? cnt_sat : 16'h0000;
      uvalid_q <= !sel_end;
      done_q   <= sel_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_unit_o   = code_q;
  assign unit_valid_o  = uvalid_q;
  assign string_done_o = done_q;
  assign total_units_o = total_q;

  a_sub_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> !q_empty_i) else $error("second result pending without command");

  a_end_item_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (!uvalid_q && code_q == 16'h0000))
    else $error("end item carries a unit");

endmodule

[hw/rtl/utf8_to_utf16_transcoder_unit.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// UTF-8 byte stream in, UTF-16 code unit stream out.
// ----------------------------------------------------------------------------
// Slave channel takes one UTF-8 byte per request in tdata[7:0]; a zero byte
// ends the string. Master channel gives one result per request: a code unit
// (tuser high) or the end item of a string (tlast high, tuser low) whose
// upper tdata half holds the saturated unit count of the string.
// A result passes through the command queue and then the output register.
// Throughput: one byte per cycle. A byte that completes a surrogate pair,
// cuts a sequence short before a single-byte lead, or ends a string inside
// a sequence gives two results, which the output sequencer sends in turn;
// the four-entry command queue absorbs such bursts, and the slave side
// stalls only when it fills.
// When the receiver stalls, the output register holds its result, the
// queue fills, and then tready on the slave side drops.
// Reset clears the partial code point, the pending byte count, the unit
// count, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] code_unit, [31:16] total_units
  output logic        m_axis_tlast_o,   // string_done
  output logic        m_axis_tuser_o    // [0] unit_valid
);
  import u8u16_pkg::*;

  cmd_t        push_cmd, head_cmd;
  logic        push, pop, q_full, q_empty;
  logic [15:0] code_unit, total_units;

  u8u16_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  u8u16_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (push_cmd),
    .full_o    (q_full),
    .rd_en_i   (pop),
    .rd_data_o (head_cmd),
    .empty_o   (q_empty)
  );

  u8u16_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (head_cmd),
    .q_empty_i     (q_empty),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .code_unit_o   (code_unit),
    .unit_valid_o  (m_axis_tuser_o),
    .string_done_o (m_axis_tlast_o),
    .total_units_o (total_units)
  );

  assign m_axis_tdata_o = {total_units, code_unit};

endmodule

[dv/utf8_to_utf16_transcoder_unit_checker.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit_checker
// Watches both stream channels of the transcoder, decodes every accepted
// UTF-8 byte into the UTF-16 results it must produce, and compares each
// accepted result field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit_checker #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        m_tlast_i,
  input  logic        m_tuser_i,
  output int          errors_o,
  output int          outstanding_o
);

  import u8u16_pkg::*;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        string_done;
    logic [15:0] total_units;
  } utf16_item_t;

  utf16_item_t           pending_utf16[$];
  logic [20:0]           code_point = '0;
  logic [1:0]            cont_left  = '0;
  logic [COUNT_BITS-1:0] unit_tally = '0;

  task automatic push_unit(input logic [15:0] unit);
    utf16_item_t item;
    item.code_unit   = unit;
    item.unit_valid  = 1'b1;
    item.string_done = 1'b0;
    item.total_units = 16'h0000;
    pending_utf16.push_back(item);
    if (unit_tally != '1) unit_tally++;
  endtask

  task automatic push_end();
    utf16_item_t item;
    logic [31:0] wide;
    wide             = 32'(unit_tally);
    item.code_unit   = 16'h0000;
    item.unit_valid  = 1'b0;
    item.string_done = 1'b1;
    item.total_units = (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
    pending_utf16.push_back(item);
  endtask

  task automatic push_code_point(input logic [20:0] cp);
    logic [20:0] offs;
    if (cp <= 21'h00_FFFF) begin
      push_unit(cp[15:0]);
    end else if (cp <= 21'h10_FFFD) begin
      offs = cp - 21'h01_0000;
      push_unit({6'b110110, offs[19:10]});
      push_unit({6'b110111, offs[9:0]});
    end else begin
      push_unit(REPL_UNIT);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [2:0] seq_len;
    if (b == 8'h00) begin
      if (cont_left != 2'd0) push_unit(REPL_UNIT);
      push_end();
      code_point = '0;
      cont_left  = '0;
      unit_tally = '0;
      return;
    end
    if (cont_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        code_point = {code_point[14:0], b[5:0]};
        cont_left--;
        if (cont_left == 2'd0) begin
          push_code_point(code_point);
          code_point = '0;
        end
        return;
      end
      push_unit(REPL_UNIT);
      cont_left  = '0;
      code_point = '0;
    end
    if (b[7:6] == 2'b10) begin
      push_unit(REPL_UNIT);
      return;
    end
    case (b[7:4])
      4'hC, 4'hD: seq_len = 3'd2;
      4'hE:       seq_len = 3'd3;
      4'hF:       seq_len = 3'd4;
      default:    seq_len = 3'd1;
    endcase
    if (seq_len == 3'd1) begin
      push_unit({8'h00, b});
    end else begin
      case (seq_len)
        3'd2:    code_point = 21'(b[4:0]);
        3'd3:    code_point = 21'(b[3:0]);
        default: code_point = 21'(b[2:0]);
      endcase
      cont_left = 2'(seq_len - 3'd1);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i) begin
    utf16_item_t want;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (pending_utf16.size() == 0) begin
          $error("result with none outstanding: tdata %h tlast %b tuser %b",
                 m_tdata_i, m_tlast_i, m_tuser_i);
          errors_o++;
        end else begin
          want = pending_utf16.pop_front();
          check_field("code_unit", want.code_unit, m_tdata_i[15:0]);
          check_field("unit_valid", 16'(want.unit_valid), 16'(m_tuser_i));
          check_field("string_done", 16'(want.string_done), 16'(m_tlast_i));
          check_field("total_units", want.total_units, m_tdata_i[31:16]);
        end
      end
      if (s_tvalid_i && s_tready_i) decode_byte(s_tdata_i);
    end
    outstanding_o <= pending_utf16.size();
  end

endmodule

[dv/utf8_to_utf16_transcoder_unit_tb.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit_tb
// Feeds the transcoder directed UTF-8 strings, a receiver hold-off that backs
// up the input, and several hundred bytes of random well-formed and broken
// sequences; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit_tb;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned RX_HOLD_CYCLES = 200;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  int errors;
  int outstanding;
  int bytes_sent     = 0;
  int rx_hold_ticket = 0;
  bit tx_no_idle     = 1'b0;
  bit rx_no_idle     = 1'b0;

  always #6 clk = ~clk;

  utf8_to_utf16_transcoder_unit #(
    .COUNT_BITS (COUNT_BITS)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  utf8_to_utf16_transcoder_unit_checker #(
    .COUNT_BITS (COUNT_BITS)
  ) i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tlast_i     (m_tlast),
    .m_tuser_i     (m_tuser),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[k]) send_byte(seq[k]);
  endtask

  // Mostly well-formed characters with random payload; some truncated,
  // some pure noise, now and then a terminator.
  task automatic send_utf8_char();
    int          pick;
    int          seq_len;
    int          conts;
    logic [7:0]  lead;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_byte(8'h00);
      return;
    end
    if (pick < 15) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    seq_len = $urandom_range(1, 4);
    case (seq_len)
      1:       lead = 8'($urandom_range(1, 127));
      2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
      3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
      default: lead = 8'hF0 | 8'($urandom_range(0, 15));
    endcase
    conts = seq_len - 1;
    if (conts > 0 && $urandom_range(0, 99) < 15) conts = $urandom_range(0, conts - 1);
    send_byte(lead);
    repeat (conts) send_byte(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  initial begin
    int stall;
    int served;
    served = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = rx_no_idle ? 0 : $urandom_range(0, 3);
      if (rx_hold_ticket != served) begin
        served = rx_hold_ticket;
        stall  = RX_HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    repeat (1_500_000) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_bytes('{8'h41, 8'h7F, 8'h01, 8'hC2, 8'hA9, 8'hC0, 8'h80, 8'hE2, 8'h82, 8'hAC,
                 8'hED, 8'hA0, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00});
    send_bytes('{8'hF4, 8'h8F, 8'hBF, 8'hBD, 8'hF4, 8'h8F, 8'hBF, 8'hBE,
                 8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hBF, 8'h00});
    send_bytes('{8'hE2, 8'h41, 8'hE2, 8'hC3, 8'hA9, 8'hF8, 8'h80, 8'hF0, 8'h9F, 8'h00,
                 8'h00});
    drain_results();

    // Back up the input behind a stalled receiver.
    tx_no_idle = 1'b1;
    rx_hold_ticket++;
    repeat (40) send_byte(8'($urandom_range(1, 127)));
    send_bytes('{8'hF0, 8'h90, 8'h80, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00});
    tx_no_idle = 1'b0;
    drain_results();

    while (bytes_sent < 330) send_utf8_char();
    drain_results();
    while (bytes_sent < 500) begin
      send_utf8_char();
      if ($urandom_range(0, 49) == 0) begin
        tx_no_idle = ~tx_no_idle;
        rx_no_idle = ~rx_no_idle;
      end
    end
    send_byte(8'h00);
    drain_results();

    repeat (10) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
